>>> rtl/palette_quantize_pack_assert.svh
// Assertion macros for the palette quantizer RTL, included by the packer.
// Each use expects clk in scope; PQP_ASSERT also expects rst_n.
`ifndef PALETTE_QUANTIZE_PACK_ASSERT_SVH
`define PALETTE_QUANTIZE_PACK_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PQP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("palette quantizer check failed");

`define PQP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("palette quantizer check failed");

`else

`define PQP_ASSERT(label, prop)

`define PQP_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> rtl/pqp_pkg.sv
`default_nettype none

package pqp_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int FIXED_ENTRIES = 2;

    localparam int BLACK_THRESHOLD_W = 22;
    localparam int COLOR_COUNT_W     = 9;
    localparam int CHAN_W            = 8;
    localparam int INDEX_W           = 8;
    localparam int SQ_W              = 16;
    localparam int DIST_W            = 18;

    localparam logic [BLACK_THRESHOLD_W-1:0] BLACK_THRESHOLD_RESET = 22'd1275000;
    localparam logic [COLOR_COUNT_W-1:0]     COLOR_COUNT_RESET     = 9'd2;

    localparam logic REG_BLACK_THRESHOLD = 1'b0;
    localparam logic REG_COLOR_COUNT     = 1'b1;

    localparam logic [INDEX_W-1:0] IDX_WHITE = 8'd0;
    localparam logic [INDEX_W-1:0] IDX_BLACK = 8'd1;

    localparam logic [23:0] WHITE_RGB = 24'hFFFFFF;
    localparam logic [23:0] BLACK_RGB = 24'h000000;

    localparam int LUMA_R = 2126;
    localparam int LUMA_G = 7152;
    localparam int LUMA_B = 722;

    typedef struct packed {
        logic                valid;
        logic                is_write;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic [INDEX_W-1:0]  idx;
        logic                row_end;
        logic [DIST_W-1:0]   best_dist;
        logic [INDEX_W-1:0]  best_idx;
    } tok_t;

    function automatic logic [1:0] bpp_log2(input logic [COLOR_COUNT_W-1:0] count);
        logic [1:0] r;
        if (count <= 9'd2)
            r = 2'd0;
        else if (count <= 9'd4)
            r = 2'd1;
        else if (count <= 9'd16)
            r = 2'd2;
        else
            r = 2'd3;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/palette_quantize_pack.sv
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     req_type red green blue entry_index row_end
// output    out_valid / out_stall   packed_byte row_last
// config    cfg_we                  cfg_index cfg_data
//
// While in_stall is low one item enters per cycle; each item walks two register
// slices per palette cell and two in the packer before its result is on the outputs.
// The whole cell chain and packer advance together; out_stall with a result waiting
// freezes every stage and raises in_stall.
// Reset clears valid bits and packing state, presets the registers; entries stay as is.

module palette_quantize_pack #(
    parameter int PALETTE_DEPTH = pqp_pkg::PALETTE_DEPTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  req_type,
    input  wire logic [7:0]                            red,
    input  wire logic [7:0]                            green,
    input  wire logic [7:0]                            blue,
    input  wire logic [7:0]                            entry_index,
    input  wire logic                                  row_end,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [7:0]                                 packed_byte,
    output logic                                       row_last,
    input  wire logic                                  cfg_we,
    input  wire logic                                  cfg_index,
    input  wire logic [pqp_pkg::BLACK_THRESHOLD_W-1:0] cfg_data
);

    logic [pqp_pkg::BLACK_THRESHOLD_W-1:0] black_threshold_reg;
    logic [pqp_pkg::COLOR_COUNT_W-1:0]     color_count_reg;
    logic                                  adv;
    pqp_pkg::tok_t                         chain [0:PALETTE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_threshold_reg <= pqp_pkg::BLACK_THRESHOLD_RESET;
            color_count_reg     <= pqp_pkg::COLOR_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pqp_pkg::REG_BLACK_THRESHOLD: black_threshold_reg <= cfg_data;
                pqp_pkg::REG_COLOR_COUNT:
                    color_count_reg <= cfg_data[pqp_pkg::COLOR_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_comb
    begin
        chain[0].valid     = in_valid;
        chain[0].is_write  = req_type;
        chain[0].red       = red;
        chain[0].green     = green;
        chain[0].blue      = blue;
        chain[0].idx       = entry_index;
        chain[0].row_end   = row_end;
        chain[0].best_dist = '1;
        chain[0].best_idx  = pqp_pkg::IDX_WHITE;
    end

    generate
        for (genvar i = 0; i < PALETTE_DEPTH; i++)
        begin : g_cell
            pqp_cell #(
                .IDX (i)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .adv         (adv),
                .color_count (color_count_reg),
                .tok_in      (chain[i]),
                .tok_out     (chain[i+1])
            );
        end
    endgenerate

    pqp_packer #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_packer (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .black_threshold (black_threshold_reg),
        .color_count     (color_count_reg),
        .tok             (chain[PALETTE_DEPTH]),
        .out_valid       (out_valid),
        .packed_byte     (packed_byte),
        .row_last        (row_last)
    );

endmodule

`default_nettype wire

>>> rtl/pqp_cell.sv
`default_nettype none

module pqp_cell #(
    parameter int IDX = 2
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  wire logic [pqp_pkg::COLOR_COUNT_W-1:0] color_count,
    input  wire pqp_pkg::tok_t                     tok_in,
    output pqp_pkg::tok_t                          tok_out
);

    localparam logic [pqp_pkg::INDEX_W-1:0]       IDX_CODE = pqp_pkg::INDEX_W'(IDX);
    localparam logic [pqp_pkg::COLOR_COUNT_W-1:0] IDX_CNT  = pqp_pkg::COLOR_COUNT_W'(IDX);

    logic [23:0] entry;

    pqp_pkg::tok_t                tok_a_reg;
    logic [pqp_pkg::SQ_W-1:0]     sq_r_reg;
    logic [pqp_pkg::SQ_W-1:0]     sq_g_reg;
    logic [pqp_pkg::SQ_W-1:0]     sq_b_reg;
    pqp_pkg::tok_t                tok_b_reg;

    logic signed [8:0]            dr;
    logic signed [8:0]            dg;
    logic signed [8:0]            db;
    logic signed [17:0]           pr;
    logic signed [17:0]           pg;
    logic signed [17:0]           pb;
    logic [pqp_pkg::DIST_W-1:0]   dist_sum;
    logic                         active;
    pqp_pkg::tok_t                tok_b_next;

    generate
        if (IDX == 0) begin : g_white
            assign entry = pqp_pkg::WHITE_RGB;
        end else if (IDX == 1) begin : g_black
            assign entry = pqp_pkg::BLACK_RGB;
        end else begin : g_loadable
            logic [23:0] entry_reg;
            always_ff @(posedge clk)
            begin
                if (adv && tok_in.valid && tok_in.is_write && tok_in.idx == IDX_CODE)
                begin
                    entry_reg <= {tok_in.red, tok_in.green, tok_in.blue};
                end
            end
            assign entry = entry_reg;
        end
    endgenerate

    always_comb
    begin
        dr = $signed({1'b0, tok_in.red})   - $signed({1'b0, entry[23:16]});
        dg = $signed({1'b0, tok_in.green}) - $signed({1'b0, entry[15:8]});
        db = $signed({1'b0, tok_in.blue})  - $signed({1'b0, entry[7:0]});
        pr = dr * dr;
        pg = dg * dg;
        pb = db * db;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg <= '0;
            tok_b_reg <= '0;
        end
        else if (adv)
        begin
            tok_a_reg <= tok_in;
            tok_b_reg <= tok_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_r_reg <= pr[pqp_pkg::SQ_W-1:0];
            sq_g_reg <= pg[pqp_pkg::SQ_W-1:0];
            sq_b_reg <= pb[pqp_pkg::SQ_W-1:0];
        end
    end

    always_comb
    begin
        dist_sum = pqp_pkg::DIST_W'(sq_r_reg) + pqp_pkg::DIST_W'(sq_g_reg)
                 + pqp_pkg::DIST_W'(sq_b_reg);
        active = (IDX < pqp_pkg::FIXED_ENTRIES) || (IDX_CNT < color_count);
        tok_b_next = tok_a_reg;
        if (tok_a_reg.valid && !tok_a_reg.is_write && active
            && dist_sum < tok_a_reg.best_dist)
        begin
            tok_b_next.best_dist = dist_sum;
            tok_b_next.best_idx  = IDX_CODE;
        end
    end

    assign tok_out = tok_b_reg;

endmodule

`default_nettype wire

>>> rtl/pqp_packer.sv
`default_nettype none

`include "palette_quantize_pack_assert.svh"

module pqp_packer #(
    parameter int PALETTE_DEPTH = pqp_pkg::PALETTE_DEPTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  adv,
    input  wire logic [pqp_pkg::BLACK_THRESHOLD_W-1:0] black_threshold,
    input  wire logic [pqp_pkg::COLOR_COUNT_W-1:0]     color_count,
    input  wire pqp_pkg::tok_t                         tok,
    output logic                                       out_valid,
    output logic [7:0]                                 packed_byte,
    output logic                                       row_last
);

    localparam logic [pqp_pkg::COLOR_COUNT_W-1:0] DEPTH_CNT =
        pqp_pkg::COLOR_COUNT_W'(PALETTE_DEPTH);
    localparam logic [pqp_pkg::COLOR_COUNT_W-1:0] FIXED_CNT =
        pqp_pkg::COLOR_COUNT_W'(pqp_pkg::FIXED_ENTRIES);
    localparam logic [pqp_pkg::INDEX_W-1:0] FIXED_IDX =
        pqp_pkg::INDEX_W'(pqp_pkg::FIXED_ENTRIES);

    logic [pqp_pkg::COLOR_COUNT_W-1:0]   cnt;
    logic [1:0]                          bpp_log;
    logic [pqp_pkg::INDEX_W-1:0]         color_sel;

    logic                                t1_valid_reg;
    logic                                t1_is_write_reg;
    logic                                t1_row_end_reg;
    logic [pqp_pkg::INDEX_W-1:0]         t1_color_reg;
    logic [19:0]                         t1_lr_reg;
    logic [20:0]                         t1_lg_reg;
    logic [17:0]                         t1_lb_reg;

    logic [7:0]                          acc_reg;
    logic [7:0]                          acc_next;
    logic [2:0]                          slot_reg;
    logic [2:0]                          slot_next;
    logic                                out_valid_reg;
    logic [7:0]                          byte_reg;
    logic [7:0]                          byte_next;
    logic                                row_last_reg;

    logic [pqp_pkg::BLACK_THRESHOLD_W-1:0] luma;
    logic [pqp_pkg::INDEX_W-1:0]         color_fin;
    logic [3:0]                          slot_inc;
    logic [6:0]                          used;
    logic [7:0]                          mask;
    logic [3:0]                          shamt;
    logic [7:0]                          acc_upd;
    logic                                emit;
    logic                                load;

    always_comb
    begin
        cnt       = (color_count > DEPTH_CNT) ? DEPTH_CNT : color_count;
        bpp_log   = pqp_pkg::bpp_log2(cnt);
        color_sel = (cnt <= FIXED_CNT) ? pqp_pkg::IDX_WHITE : tok.best_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t1_valid_reg  <= tok.valid;
            acc_reg       <= acc_next;
            slot_reg      <= slot_next;
            out_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_is_write_reg <= tok.is_write;
            t1_row_end_reg  <= tok.row_end;
            t1_color_reg    <= color_sel;
            t1_lr_reg       <= 20'(pqp_pkg::LUMA_R * tok.red);
            t1_lg_reg       <= 21'(pqp_pkg::LUMA_G * tok.green);
            t1_lb_reg       <= 18'(pqp_pkg::LUMA_B * tok.blue);
            if (load)
            begin
                byte_reg     <= byte_next;
                row_last_reg <= t1_row_end_reg;
            end
        end
    end

    always_comb
    begin
        luma = pqp_pkg::BLACK_THRESHOLD_W'(t1_lr_reg) + pqp_pkg::BLACK_THRESHOLD_W'(t1_lg_reg)
             + pqp_pkg::BLACK_THRESHOLD_W'(t1_lb_reg);
        color_fin = (t1_color_reg < FIXED_IDX && luma <= black_threshold)
                  ? pqp_pkg::IDX_BLACK : t1_color_reg;

        case (bpp_log)
            2'd0:    mask = 8'h01;
            2'd1:    mask = 8'h03;
            2'd2:    mask = 8'h0F;
            default: mask = 8'hFF;
        endcase

        slot_inc = {1'b0, slot_reg} + 4'd1;
        used     = 7'(slot_inc) << bpp_log;
        shamt    = 4'(7'd8 - used);

        acc_next  = acc_reg;
        slot_next = slot_reg;
        acc_upd   = acc_reg;
        byte_next = acc_reg;
        emit      = 1'b0;
        load      = 1'b0;

        if (t1_valid_reg && !t1_is_write_reg)
        begin
            if (used <= 7'd8)
            begin
                acc_upd   = acc_reg | ((color_fin & mask) << shamt);
                slot_next = slot_inc[2:0];
                acc_next  = acc_upd;
                emit      = (used == 7'd8) || t1_row_end_reg;
            end
            else
            begin
                emit = 1'b1;
            end
            if (emit)
            begin
                load      = 1'b1;
                byte_next = acc_upd;
                acc_next  = '0;
                slot_next = '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign packed_byte = byte_reg;
    assign row_last    = row_last_reg;

    `PQP_ASSERT(a_row_end_clears, adv && t1_valid_reg && !t1_is_write_reg && t1_row_end_reg |=> slot_reg == 3'd0 && acc_reg == 8'd0)
    `PQP_ASSERT(a_write_no_result, adv && t1_valid_reg && t1_is_write_reg |=> !out_valid_reg)
    `PQP_ASSERT(a_hold_on_stall, !adv |=> $stable(slot_reg) && $stable(acc_reg) && $stable(byte_reg))

endmodule

`default_nettype wire

>>> verif/palette_quantize_pack_tb.sv
`timescale 1ns / 100ps

module palette_quantize_pack_tb;
    import pqp_pkg::*;

    localparam int LATENCY = 2 * PALETTE_DEPTH + 2;
    localparam int IDLE_LIMIT = 4 * LATENCY + 2000;
    localparam int RANDOM_ITEMS = 640;
    localparam int PLAN_ROWS = 31;
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_ENTRY = 1'b1;

    typedef struct packed {
        logic       req;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] slot;
        logic       eor;
    } px_item_t;

    typedef struct packed {
        logic [7:0] bits;
        logic       last;
    } pack_out_t;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_ENTRY, ROW_THRESH, ROW_COUNT} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  slot;
        logic        eor;
        logic [21:0] value;
        logic        typed;
        logic [7:0]  want_bits;
        logic        want_last;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [7:0]  red = 8'd0;
    logic [7:0]  green = 8'd0;
    logic [7:0]  blue = 8'd0;
    logic [7:0]  entry_index = 8'd0;
    logic        row_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  packed_byte;
    logic        row_last;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [21:0] cfg_data = 22'd0;

    logic [23:0] palette_rgb [PALETTE_DEPTH];
    bit          loaded [PALETTE_DEPTH];
    logic [7:0]  pack_acc;
    int unsigned held;
    logic [21:0] thresh;
    logic [8:0]  count_reg;
    pack_out_t   pending_bytes [$];
    int          mismatches = 0;
    bit          calm = 1'b0;
    bit          dirty = 1'b0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_PIXEL,  255, 255, 255,   0, 1,       0, 1, 'h00, 1},
        '{ROW_PIXEL,    0,   0,   0,   0, 1,       0, 1, 'h80, 1},
        '{ROW_PIXEL,    0,   0,   0, 255, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,  255, 255, 255,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,    0,   0,   0,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,  255, 255, 255,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,    0,   0,   0,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,  255, 255, 255,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,    0,   0,   0,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,  255, 255, 255,   0, 0,       0, 1, 'hAA, 0},
        '{ROW_THRESH,   0,   0,   0,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,    0,   0,   0,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,    0,   0,   1,   0, 1,       0, 1, 'h80, 1},
        '{ROW_THRESH,   0,   0,   0,   0, 0, 1000000, 0, 'h00, 0},
        '{ROW_PIXEL,  100, 100, 101,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,  100, 100, 100,   0, 1,       0, 1, 'h40, 1},
        '{ROW_ENTRY,    0,   0,   0,   0, 0,       0, 0, 'h00, 0},
        '{ROW_ENTRY,  255, 255, 255,   1, 0,       0, 0, 'h00, 0},
        '{ROW_ENTRY,  255,   0,   0,   2, 0,       0, 0, 'h00, 0},
        '{ROW_ENTRY,    0,   0, 255,   3, 0,       0, 0, 'h00, 0},
        '{ROW_COUNT,    0,   0,   0,   0, 0,       4, 0, 'h00, 0},
        '{ROW_THRESH,   0,   0,   0,   0, 0, 2550000, 0, 'h00, 0},
        '{ROW_PIXEL,  250,  10,  10,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,  255, 255, 255,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,    0,   0, 255,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,   10,  10,  10,   0, 1,       0, 1, 'h9D, 1},
        '{ROW_PIXEL,  128,   0, 128,   0, 0,       0, 0, 'h00, 0},
        '{ROW_COUNT,    0,   0,   0,   0, 0,     300, 0, 'h00, 0},
        '{ROW_PIXEL,    0,   0,   0,   0, 0,       0, 1, 'h80, 0},
        '{ROW_COUNT,    0,   0,   0,   0, 0,       0, 0, 'h00, 0},
        '{ROW_PIXEL,  255, 255, 255,   0, 1,       0, 1, 'h80, 1}
    };

    palette_quantize_pack uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .entry_index (entry_index),
        .row_end     (row_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packed_byte (packed_byte),
        .row_last    (row_last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned live_colors();
        if (count_reg < 9'd2)
            return 2;
        if (count_reg > PALETTE_DEPTH)
            return PALETTE_DEPTH;
        return count_reg;
    endfunction

    function automatic int unsigned rgb_dist(input px_item_t q, input logic [23:0] e);
        int dr;
        int dg;
        int db;
        dr = int'(q.r) - int'(e[23:16]);
        dg = int'(q.g) - int'(e[15:8]);
        db = int'(q.b) - int'(e[7:0]);
        return dr * dr + dg * dg + db * db;
    endfunction

    task automatic quantize_and_pack(input px_item_t q, output bit emits,
                                     output pack_out_t res);
        int unsigned n;
        int unsigned width;
        int unsigned color;
        int unsigned best;
        int unsigned d;
        int unsigned used;
        logic [31:0] luma;
        emits = 1'b0;
        res = '0;
        if (q.req == REQ_ENTRY)
        begin
            if (q.slot >= FIXED_ENTRIES)
            begin
                palette_rgb[q.slot] = {q.r, q.g, q.b};
                loaded[q.slot] = 1'b1;
            end
            return;
        end
        n = live_colors();
        width = n <= 2 ? 1 : n <= 4 ? 2 : n <= 16 ? 4 : 8;
        color = 0;
        if (n > 2)
        begin
            best = rgb_dist(q, palette_rgb[0]);
            for (int k = 1; k < n; k++)
            begin
                d = rgb_dist(q, palette_rgb[k]);
                if (d < best)
                begin
                    best = d;
                    color = k;
                end
            end
        end
        if (color < FIXED_ENTRIES)
        begin
            luma = LUMA_R * q.r + LUMA_G * q.g + LUMA_B * q.b;
            if (luma <= thresh)
                color = IDX_BLACK;
        end
        used = width * (held + 1);
        if (used <= 8)
        begin
            pack_acc = pack_acc | 8'((color & ((1 << width) - 1)) << (8 - used));
            held = (held + 1) % 8;
            emits = (used == 8) || q.eor;
        end
        else
            emits = 1'b1;
        if (emits)
        begin
            res.bits = pack_acc;
            res.last = q.eor;
            pack_acc = 8'd0;
            held = 0;
        end
    endtask

    task automatic offer_item(input px_item_t q, input bit typed, input pack_out_t want);
        bit fire;
        bit emits;
        pack_out_t res;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= q.req;
        red <= q.r;
        green <= q.g;
        blue <= q.b;
        entry_index <= q.slot;
        row_end <= q.eor;
        do
        begin
            @(negedge clk);
            fire = in_valid && !in_stall;
            @(posedge clk);
        end
        while (!fire);
        quantize_and_pack(q, emits, res);
        if (typed)
            pending_bytes.push_back(want);
        else if (emits)
            pending_bytes.push_back(res);
        dirty = 1'b1;
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        if (dirty)
        begin
            while (pending_bytes.size() != 0) @(posedge clk);
            repeat (LATENCY + 8) @(posedge clk);
            dirty = 1'b0;
        end
    endtask

    task automatic write_setting(input logic sel, input logic [21:0] value);
        px_item_t q;
        quiesce();
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (sel == REG_BLACK_THRESHOLD)
            thresh = value;
        else
        begin
            count_reg = value[8:0];
            // load every entry in use that was never written
            for (int k = FIXED_ENTRIES; k < live_colors(); k++)
            begin
                if (!loaded[k])
                begin
                    q.req = REQ_ENTRY;
                    {q.r, q.g, q.b} = 24'($urandom);
                    q.slot = k;
                    q.eor = 1'($urandom_range(0, 1));
                    offer_item(q, 1'b0, '0);
                end
            end
        end
    endtask

    function automatic logic [21:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return 22'd0;
            1: return 22'd2550000;
            2: return 22'h3FFFFF;
            3: return 22'($urandom_range(0, 22'h3FFFFF));
            default: return 22'($urandom_range(300000, 2300000));
        endcase
    endfunction

    function automatic logic [21:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 22'($urandom_range(0, 1));
            1: return 22'd2;
            2: return 22'($urandom_range(3, 4));
            3, 4: return 22'($urandom_range(5, 16));
            5, 6: return 22'($urandom_range(17, 48));
            7: return 22'($urandom_range(49, 256));
            8: return 22'($urandom_range(257, 511));
            default: return 22'd256;
        endcase
    endfunction

    function automatic px_item_t random_item();
        px_item_t q;
        logic [23:0] c;
        int v;
        q.slot = 8'($urandom_range(0, 255));
        q.eor = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) == 0)
        begin
            q.req = REQ_ENTRY;
            // duplicate an entry now and then to force ties
            if ($urandom_range(0, 3) == 0)
                c = palette_rgb[$urandom_range(0, PALETTE_DEPTH - 1)];
            else
                c = 24'($urandom);
        end
        else
        begin
            q.req = REQ_PIXEL;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    c = palette_rgb[$urandom_range(0, live_colors() - 1)];
                    for (int j = 0; j < 3; j++)
                    begin
                        v = int'(c[8*j +: 8]) + $urandom_range(0, 6) - 3;
                        c[8*j +: 8] = v < 0 ? 8'd0 : v > 255 ? 8'd255 : 8'(v);
                    end
                end
                4, 5: c = {8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                           8'($urandom_range(0, 1) * 255)};
                default: c = 24'($urandom);
            endcase
        end
        {q.r, q.g, q.b} = c;
        return q;
    endfunction

    task automatic flag(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    initial
    begin
        pack_out_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_bytes.size() == 0)
                    flag($sformatf("unexpected byte %02h row_last %0b", packed_byte, row_last));
                else
                begin
                    want = pending_bytes.pop_front();
                    if (packed_byte !== want.bits)
                        flag($sformatf("packed_byte mismatch: expected %02h got %02h",
                                       want.bits, packed_byte));
                    if (row_last !== want.last)
                        flag($sformatf("row_last mismatch: expected %0b got %0b",
                                       want.last, row_last));
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 15) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        px_item_t q;
        pack_out_t want;
        int done;
        int n;
        int phase_no;
        for (int k = 0; k < PALETTE_DEPTH; k++)
        begin
            palette_rgb[k] = 24'd0;
            loaded[k] = 1'b0;
        end
        palette_rgb[IDX_WHITE] = WHITE_RGB;
        palette_rgb[IDX_BLACK] = BLACK_RGB;
        loaded[IDX_WHITE] = 1'b1;
        loaded[IDX_BLACK] = 1'b1;
        pack_acc = 8'd0;
        held = 0;
        thresh = BLACK_THRESHOLD_RESET;
        count_reg = COLOR_COUNT_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            case (plan[i].kind)
                ROW_THRESH: write_setting(REG_BLACK_THRESHOLD, plan[i].value);
                ROW_COUNT: write_setting(REG_COLOR_COUNT, plan[i].value);
                default:
                begin
                    q.req = plan[i].kind == ROW_ENTRY ? REQ_ENTRY : REQ_PIXEL;
                    q.r = plan[i].r;
                    q.g = plan[i].g;
                    q.b = plan[i].b;
                    q.slot = plan[i].slot;
                    q.eor = plan[i].eor;
                    want.bits = plan[i].want_bits;
                    want.last = plan[i].want_last;
                    offer_item(q, plan[i].typed, want);
                end
            endcase
        end

        done = 0;
        phase_no = 0;
        while (done < RANDOM_ITEMS)
        begin
            n = $urandom_range(40, 140);
            if (RANDOM_ITEMS - done <= 160)
            begin
                n = RANDOM_ITEMS - done;
                calm = 1'b1;
            end
            if ($urandom_range(0, 1))
            begin
                write_setting(REG_BLACK_THRESHOLD, pick_threshold());
                write_setting(REG_COLOR_COUNT, pick_count());
            end
            else
            begin
                write_setting(REG_COLOR_COUNT, pick_count());
                write_setting(REG_BLACK_THRESHOLD, pick_threshold());
            end
            for (int k = 0; k < n; k++)
            begin
                // hold the sender until every pending byte has come out
                if (k == n / 2 && (phase_no == 0 || $urandom_range(0, 2) == 0))
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_bytes.size() != 0);
                end
                offer_item(random_item(), 1'b0, '0);
            end
            done += n;
            phase_no++;
        end

        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (LATENCY + 16) @(posedge clk);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
